// ===== rtl/core/timed_event_queue_unit_assert.svh =====
// ----------------------------------------------------------------------------
// timed event queue assertion macros
// shared property forms for the checker: implication in the same cycle and
// implication into the next cycle, both off while reset is high
// ----------------------------------------------------------------------------
`ifndef TIMED_EVENT_QUEUE_UNIT_ASSERT_SVH
`define TIMED_EVENT_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication
`define TEQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TEQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/teq_pkg.sv =====
// ----------------------------------------------------------------------------
// teq_pkg
// shared widths, operation and status codes, and cell control for the
// timed event queue
// ----------------------------------------------------------------------------
package teq_pkg;

  localparam int TICK_W         = 64;
  localparam int KIND_W         = 3;
  localparam int STATUS_W       = 2;
  localparam int MAX_EVENTS_DEF = 64;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_ALLOC   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SCHED   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DESCHED = 3'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DEALLOC = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_UNKNOWN   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd2;

  // per-cycle command broadcast to every cell of the row
  typedef struct packed {
    logic rem;  // close the gap at the matching slot, shift left
    logic ins;  // open a gap at the sorted place, shift right
  } cell_ctrl_t;

endpackage

// ===== rtl/core/teq_ram.sv =====
// ----------------------------------------------------------------------------
// teq_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module teq_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/teq_cell.sv =====
// ----------------------------------------------------------------------------
// teq_cell
// one slot of the sorted queue; compares against the broadcast key and
// takes the word of its left or right neighbor, or the new key word, on insert or remove
// ----------------------------------------------------------------------------
module teq_cell import teq_pkg::*; #(
  parameter int IDW = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  cell_ctrl_t        ctrl,
  input  logic [IDW-1:0]    key_id,
  input  logic [TICK_W-1:0] key_tick,
  input  logic              left_valid,
  input  logic [IDW-1:0]    left_id,
  input  logic [TICK_W-1:0] left_tick,
  input  logic              left_gt,
  input  logic              right_valid,
  input  logic [IDW-1:0]    right_id,
  input  logic [TICK_W-1:0] right_tick,
  input  logic              del_in,
  output logic              slot_valid,
  output logic [IDW-1:0]    slot_id,
  output logic [TICK_W-1:0] slot_tick,
  output logic              gt,
  output logic              del_out,
  output logic              match,
  output logic [TICK_W-1:0] found
);

  logic              load;
  logic              valid_next;
  logic [IDW-1:0]    id_next;
  logic [TICK_W-1:0] tick_next;

  assign match   = slot_valid && (slot_id == key_id);
  // empty slots sort after everything
  assign gt      = !slot_valid || (slot_tick > key_tick);
  assign del_out = del_in | match;
  assign found   = match ? slot_tick : '0;

  always_comb begin
    load       = 1'b0;
    valid_next = slot_valid;
    id_next    = slot_id;
    tick_next  = slot_tick;
    if (ctrl.rem && del_out) begin
      load       = 1'b1;
      valid_next = right_valid;
      id_next    = right_id;
      tick_next  = right_tick;
    end else if (ctrl.ins && left_gt) begin
      load       = 1'b1;
      valid_next = left_valid;
      id_next    = left_id;
      tick_next  = left_tick;
    end else if (ctrl.ins && gt) begin
      // first slot past the equal-or-lower run takes the new word
      load       = 1'b1;
      valid_next = 1'b1;
      id_next    = key_id;
      tick_next  = key_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (load) begin
      slot_valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_id   <= id_next;
      slot_tick <= tick_next;
    end
  end

endmodule

// ===== rtl/core/timed_event_queue_unit.sv =====
// ----------------------------------------------------------------------------
// timed_event_queue_unit
// time-ordered event queue with id allocation, built as a row of queue cells
// ----------------------------------------------------------------------------
// An operation word is taken at a rising edge where start is high and busy is
// low. Its result is marked on the result ports by done, high for exactly one
// cycle; the receiver cannot stall, so it must take the word in that cycle.
// Every operation passes from the accepting edge through the lookup and
// execute states to the output state, where done is high; a schedule that
// places an entry (a new one or a move to another tick) also passes through
// the insert state before output. busy is low while done is high, so the next
// word can be accepted in that cycle, but no word is taken while one is in
// flight. The sequence is set by the registered read of the id map, a lookup
// across the cell row, and separate remove and insert passes, each one shift
// of the whole row. There is no clearing pass after reset: the id map is
// covered by the allocation counter, so the block takes words as soon as
// reset is released. The head fields show the earliest queued event after
// the operation, ties kept in arrival order.
// ----------------------------------------------------------------------------
module timed_event_queue_unit import teq_pkg::*; #(
  parameter int MAX_EVENTS = MAX_EVENTS_DEF,
  localparam int IDW       = $clog2(MAX_EVENTS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [KIND_W-1:0]   kind,
  input  logic [IDW-1:0]      event_id,
  input  logic [TICK_W-1:0]   tick,
  input  logic [TICK_W-1:0]   now,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic                was_present,
  output logic                rescheduled,
  output logic [TICK_W-1:0]   found_tick,
  output logic [IDW-1:0]      new_id,
  output logic                head_valid,
  output logic [IDW-1:0]      head_id,
  output logic [TICK_W-1:0]   head_tick
);

  localparam int AW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int N  = MAX_EVENTS;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_INS  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state;
  logic       accept;

  // latched operation word, tick already clamped up to now
  logic [KIND_W-1:0]   cmd_kind;
  logic [IDW-1:0]      cmd_id;
  logic [TICK_W-1:0]   cmd_tick;

  // allocation counter: ids 1..next_id have been handed out
  logic [IDW-1:0]      next_id;
  logic                alloc_ok;
  logic                hit_known;

  // result word
  logic [STATUS_W-1:0] res_status;
  logic                res_present;
  logic                res_resched;
  logic [TICK_W-1:0]   res_found;
  logic [IDW-1:0]      res_new_id;

  // id map: one live bit per id, written on allocate and deallocate
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [0:0]          ram_wdata;
  logic [0:0]          ram_rdata;

  // cell row links
  cell_ctrl_t          cell_ctrl;
  logic                go_ins;
  logic                c_valid [N];
  logic [IDW-1:0]      c_id    [N];
  logic [TICK_W-1:0]   c_tick  [N];
  logic                c_gt    [N];
  logic                c_del   [N];
  logic                c_match [N];
  logic [TICK_W-1:0]   c_found [N];
  logic                match_any;
  logic [TICK_W-1:0]   found_or;
  logic                known_now;
  logic                is_id_op;

  assign busy   = (state inside {S_LOOK, S_EXEC, S_INS});
  assign accept = start && !busy;

  // ---------------------------------------------------------------- id map
  teq_ram #(
    .WIDTH (1),
    .DEPTH (MAX_EVENTS)
  ) u_idmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (AW'(event_id - IDW'(1))),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- cell row
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic              l_valid;
    logic [IDW-1:0]    l_id;
    logic [TICK_W-1:0] l_tick;
    logic              l_gt;
    logic              l_del;
    logic              r_valid;
    logic [IDW-1:0]    r_id;
    logic [TICK_W-1:0] r_tick;

    if (i == 0) begin : g_left_edge
      // head slot: nothing to its left
      assign l_valid = 1'b0;
      assign l_id    = '0;
      assign l_tick  = '0;
      assign l_gt    = 1'b0;
      assign l_del   = 1'b0;
    end else begin : g_left
      assign l_valid = c_valid[i-1];
      assign l_id    = c_id[i-1];
      assign l_tick  = c_tick[i-1];
      assign l_gt    = c_gt[i-1];
      assign l_del   = c_del[i-1];
    end

    if (i == N - 1) begin : g_right_edge
      // tail slot: an empty word shifts in on remove
      assign r_valid = 1'b0;
      assign r_id    = '0;
      assign r_tick  = '0;
    end else begin : g_right
      assign r_valid = c_valid[i+1];
      assign r_id    = c_id[i+1];
      assign r_tick  = c_tick[i+1];
    end

    teq_cell #(
      .IDW (IDW)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (cell_ctrl),
      .key_id      (cmd_id),
      .key_tick    (cmd_tick),
      .left_valid  (l_valid),
      .left_id     (l_id),
      .left_tick   (l_tick),
      .left_gt     (l_gt),
      .right_valid (r_valid),
      .right_id    (r_id),
      .right_tick  (r_tick),
      .del_in      (l_del),
      .slot_valid  (c_valid[i]),
      .slot_id     (c_id[i]),
      .slot_tick   (c_tick[i]),
      .gt          (c_gt[i]),
      .del_out     (c_del[i]),
      .match       (c_match[i]),
      .found       (c_found[i])
    );
  end

  // ids are unique in the queue, so at most one slot matches
  always_comb begin
    match_any = 1'b0;
    found_or  = '0;
    for (int i = 0; i < N; i++) begin
      match_any = match_any | c_match[i];
      found_or  = found_or | c_found[i];
    end
  end

  // ---------------------------------------------------------------- control
  assign is_id_op  = (cmd_kind inside {[KIND_SCHED:KIND_DEALLOC]});
  assign known_now = (cmd_id != '0) && (cmd_id <= next_id) && ram_rdata[0];
  assign alloc_ok  = (next_id < IDW'(MAX_EVENTS));

  always_comb begin
    cell_ctrl = '0;
    go_ins    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = AW'(cmd_id - IDW'(1));
    ram_wdata = 1'b0;
    if (state == S_EXEC) begin
      if (cmd_kind == KIND_ALLOC) begin
        if (alloc_ok) begin
          // new id is next_id + 1, its map entry sits at next_id
          ram_we    = 1'b1;
          ram_waddr = AW'(next_id);
          ram_wdata = 1'b1;
        end
      end else if (hit_known) begin
        case (cmd_kind)
          KIND_SCHED: begin
            if (!res_present) begin
              go_ins = 1'b1;
            end else if (res_found != cmd_tick) begin
              // move: pull the old entry now, place the new one next cycle
              cell_ctrl.rem = 1'b1;
              go_ins        = 1'b1;
            end
          end
          KIND_DESCHED: begin
            cell_ctrl.rem = 1'b1;
          end
          KIND_DEALLOC: begin
            cell_ctrl.rem = 1'b1;
            ram_we        = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end else if (state == S_INS) begin
      cell_ctrl.ins = 1'b1;
    end
  end

  // sequencer and allocation counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      next_id <= '0;
    end else begin
      case (state)
        S_IDLE, S_OUT: begin
          state <= start ? S_LOOK : S_IDLE;
        end
        S_LOOK: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          state <= go_ins ? S_INS : S_OUT;
          if (cmd_kind == KIND_ALLOC && alloc_ok) begin
            next_id <= next_id + IDW'(1);
          end
        end
        S_INS: begin
          state <= S_OUT;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // operation word and result word
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_kind    <= kind;
      cmd_id      <= event_id;
      cmd_tick    <= (tick < now) ? now : tick;
      res_status  <= STATUS_OK;
      res_present <= 1'b0;
      res_resched <= 1'b0;
      res_found   <= '0;
      res_new_id  <= '0;
    end else if (state == S_LOOK) begin
      hit_known   <= known_now;
      res_present <= is_id_op && known_now && match_any;
      res_found   <= ((cmd_kind == KIND_SCHED || cmd_kind == KIND_QUERY) &&
                      known_now && match_any) ? found_or : '0;
    end else if (state == S_EXEC) begin
      if (cmd_kind == KIND_ALLOC) begin
        if (alloc_ok) begin
          res_new_id <= next_id + IDW'(1);
        end else begin
          res_status <= STATUS_EXHAUSTED;
        end
      end else if (is_id_op && !hit_known) begin
        res_status <= STATUS_UNKNOWN;
      end else if (cmd_kind == KIND_SCHED && res_present &&
                   res_found != cmd_tick) begin
        res_resched <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- outputs
  assign done        = (state == S_OUT);
  assign status      = res_status;
  assign was_present = res_present;
  assign rescheduled = res_resched;
  assign found_tick  = res_found;
  assign new_id      = res_new_id;
  // head slot is the earliest event; zeros when the queue is empty
  assign head_valid  = c_valid[0];
  assign head_id     = c_valid[0] ? c_id[0] : '0;
  assign head_tick   = c_valid[0] ? c_tick[0] : '0;

endmodule

// ===== rtl/core/teq_checker.sv =====
// ----------------------------------------------------------------------------
// teq_checker
// port-level checks on the timed event queue, bound to the top level
// ----------------------------------------------------------------------------
`include "timed_event_queue_unit_assert.svh"

module teq_checker import teq_pkg::*; #(
  parameter int MAX_EVENTS = MAX_EVENTS_DEF,
  localparam int IDW       = $clog2(MAX_EVENTS + 1)
) (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input logic [STATUS_W-1:0] status,
  input logic                was_present,
  input logic                rescheduled,
  input logic [TICK_W-1:0]   found_tick,
  input logic [IDW-1:0]      new_id,
  input logic                head_valid,
  input logic [IDW-1:0]      head_id,
  input logic [TICK_W-1:0]   head_tick
);

  // an accepted word keeps the block busy and cannot finish at once
  `TEQ_ASSERT_NXT(a_accept_busy, start && !busy, busy && !done, "accepted word not held busy")

  // each word gives a single result cycle
  `TEQ_ASSERT_NXT(a_done_single, done, !done, "done held for more than one cycle")

  // rejected id leaves every other result field clear
  `TEQ_ASSERT_IMP(a_unknown_clean, done && status == STATUS_UNKNOWN, new_id == '0 && !was_present && !rescheduled && found_tick == '0, "unknown id with result fields set")

  // empty queue shows a zero head
  `TEQ_ASSERT_IMP(a_head_empty, done && !head_valid, head_id == '0 && head_tick == '0, "empty queue with nonzero head")

endmodule

bind timed_event_queue_unit teq_checker #(.MAX_EVENTS(MAX_EVENTS)) u_teq_checker (.*);
